>>> src/cau_pkg.sv
// shared types and constants for the complex arithmetic unit
`timescale 1ns / 1ps
`default_nettype none
package cau_pkg;

  typedef enum logic [2:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_MUL  = 3'd2,
    CMD_MULR = 3'd3,
    CMD_DIV  = 3'd4,
    CMD_DIVR = 3'd5
  } cmd_e;

  localparam int DIV_STEPS = 32;
  localparam int LATENCY   = DIV_STEPS + 5;

  localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic        is_div;
    logic        dz;
    logic        sat;
    logic [31:0] y_re;
    logic [31:0] y_im;
  } res_t;

  typedef struct packed {
    res_t        res;
    logic [1:0]  neg;
    logic [1:0]  ovf;
    logic [63:0] den;
    logic [63:0] rem_re;
    logic [63:0] rem_im;
    logic [31:0] lo_re;
    logic [31:0] lo_im;
    logic [31:0] q_re;
    logic [31:0] q_im;
  } dstage_t;

endpackage
`default_nettype wire

>>> src/complex_arith_unit_core.sv
// pipelined complex arithmetic unit over signed fixed point
// every command runs the full pipeline, from an accepted start beat to its done strobe
// throughput: one beat per cycle; busy_o stays low, the 32-stage divider is fully pipelined
// the divider retires one quotient bit per stage, which sets the depth
// reset clears all valid bits and the output flags; other payload registers are not reset
`timescale 1ns / 1ps
`default_nettype none
module complex_arith_unit_core #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [2:0]         cmd_i,
  input  wire logic signed [31:0] a_re_i,
  input  wire logic signed [31:0] a_im_i,
  input  wire logic signed [31:0] b_re_i,
  input  wire logic signed [31:0] b_im_i,
  output logic                    done_o,
  output logic signed [31:0]      y_re_o,
  output logic signed [31:0]      y_im_o,
  output logic                    saturated_o,
  output logic                    div_by_zero_o
);
  import cau_pkg::*;

  function automatic logic signed [64:0] sx64(input logic signed [63:0] x);
    sx64 = $signed({x[63], x});
  endfunction

  function automatic logic [32:0] sat_fn(input logic signed [65:0] v);
    logic [32:0] r;
    r = {1'b0, v[31:0]};
    if (v > $signed({34'd0, SAT_MAX})) begin
      r = {1'b1, SAT_MAX};
    end else if (v < $signed({{34{1'b1}}, SAT_MIN})) begin
      r = {1'b1, SAT_MIN};
    end
    sat_fn = r;
  endfunction

  assign busy_o = 1'b0;

  // stage 1: products and add/sub
  logic                     v1_q;
  logic [2:0]               cmd1_q;
  logic signed [63:0]       p_rr_q, p_ii_q, p_ri_q, p_ir_q, p_bbr_q, p_bbi_q;
  logic signed [32:0]       as_re_q, as_im_q;
  logic signed [31:0]       ar1_q, ai1_q, br1_q;
  logic signed [32:0]       as_re_d, as_im_d;

  always_comb begin
    if (cmd_i == CMD_SUB) begin
      as_re_d = $signed({a_re_i[31], a_re_i}) - $signed({b_re_i[31], b_re_i});
      as_im_d = $signed({a_im_i[31], a_im_i}) - $signed({b_im_i[31], b_im_i});
    end else begin
      as_re_d = $signed({a_re_i[31], a_re_i}) + $signed({b_re_i[31], b_re_i});
      as_im_d = $signed({a_im_i[31], a_im_i}) + $signed({b_im_i[31], b_im_i});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start_i & ~busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd1_q  <= cmd_i;
    p_rr_q  <= a_re_i * b_re_i;
    p_ii_q  <= a_im_i * b_im_i;
    p_ri_q  <= a_re_i * b_im_i;
    p_ir_q  <= a_im_i * b_re_i;
    p_bbr_q <= b_re_i * b_re_i;
    p_bbi_q <= b_im_i * b_im_i;
    as_re_q <= as_re_d;
    as_im_q <= as_im_d;
    ar1_q   <= a_re_i;
    ai1_q   <= a_im_i;
    br1_q   <= b_re_i;
  end

  // stage 2: exact sums and denominator
  logic                     v2_q;
  logic [2:0]               cmd2_q;
  logic signed [64:0]       sum_re_q, sum_im_q, sum_re_d, sum_im_d;
  logic [63:0]              den2_q, den2_d;
  logic                     dneg2_q, dneg2_d;

  always_comb begin
    sum_re_d = '0;
    sum_im_d = '0;
    den2_d   = '0;
    dneg2_d  = 1'b0;
    case (cmd1_q)
      CMD_ADD, CMD_SUB: begin
        sum_re_d = $signed({{32{as_re_q[32]}}, as_re_q});
        sum_im_d = $signed({{32{as_im_q[32]}}, as_im_q});
      end
      CMD_MUL: begin
        sum_re_d = sx64(p_rr_q) - sx64(p_ii_q);
        sum_im_d = sx64(p_ri_q) + sx64(p_ir_q);
      end
      CMD_MULR: begin
        sum_re_d = sx64(p_rr_q);
        sum_im_d = sx64(p_ir_q);
      end
      CMD_DIV: begin
        sum_re_d = sx64(p_rr_q) + sx64(p_ii_q);
        sum_im_d = sx64(p_ir_q) - sx64(p_ri_q);
        den2_d   = $unsigned(p_bbr_q) + $unsigned(p_bbi_q);
      end
      CMD_DIVR: begin
        sum_re_d = $signed({{33{ar1_q[31]}}, ar1_q});
        sum_im_d = $signed({{33{ai1_q[31]}}, ai1_q});
        den2_d   = br1_q[31] ? 64'(-$signed({{32{br1_q[31]}}, br1_q}))
                             : {32'd0, br1_q};
        dneg2_d  = br1_q[31];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd2_q   <= cmd1_q;
    sum_re_q <= sum_re_d;
    sum_im_q <= sum_im_d;
    den2_q   <= den2_d;
    dneg2_q  <= dneg2_d;
  end

  // stage 3: rounding and saturation of the fast ops, magnitudes for the divider
  logic signed [65:0]       shr_re, shr_im, rnd_re, rnd_im;
  logic [32:0]              fr_re, fr_im;
  res_t                     res3_d;
  logic                     v3_q;
  res_t                     res3_q;
  logic [1:0]               neg3_q;
  logic [63:0]              den3_q, mag_re_q, mag_im_q;

  assign shr_re = $signed({sum_re_q[64], sum_re_q}) >>> FRAC_BITS;
  assign shr_im = $signed({sum_im_q[64], sum_im_q}) >>> FRAC_BITS;

  if (FRAC_BITS > 0) begin : g_rnd
    assign rnd_re = shr_re + $signed({65'd0, sum_re_q[FRAC_BITS-1]});
    assign rnd_im = shr_im + $signed({65'd0, sum_im_q[FRAC_BITS-1]});
  end else begin : g_nornd
    assign rnd_re = shr_re;
    assign rnd_im = shr_im;
  end

  always_comb begin
    res3_d = '0;
    fr_re  = '0;
    fr_im  = '0;
    case (cmd2_q)
      CMD_ADD, CMD_SUB: begin
        fr_re = sat_fn($signed({sum_re_q[64], sum_re_q}));
        fr_im = sat_fn($signed({sum_im_q[64], sum_im_q}));
      end
      CMD_MUL, CMD_MULR: begin
        fr_re = sat_fn(rnd_re);
        fr_im = sat_fn(rnd_im);
      end
      CMD_DIV, CMD_DIVR: begin
        res3_d.is_div = 1'b1;
        res3_d.dz     = (den2_q == 64'd0);
      end
      default: begin
      end
    endcase
    res3_d.sat  = fr_re[32] | fr_im[32];
    res3_d.y_re = fr_re[31:0];
    res3_d.y_im = fr_im[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res3_q   <= res3_d;
    neg3_q   <= {sum_im_q[64] ^ dneg2_q, sum_re_q[64] ^ dneg2_q};
    den3_q   <= den2_q;
    mag_re_q <= sum_re_q[64] ? 64'(-sum_re_q) : sum_re_q[63:0];
    mag_im_q <= sum_im_q[64] ? 64'(-sum_im_q) : sum_im_q[63:0];
  end

  // divider: overflow check, then one quotient bit per stage
  dstage_t                  d_q [0:DIV_STEPS];
  logic                     dv_q [0:DIV_STEPS];
  dstage_t                  d0_d;
  logic [63:0]              hi_re, hi_im, shl_re, shl_im;

  assign hi_re  = mag_re_q >> (32 - FRAC_BITS);
  assign hi_im  = mag_im_q >> (32 - FRAC_BITS);
  assign shl_re = mag_re_q << FRAC_BITS;
  assign shl_im = mag_im_q << FRAC_BITS;

  always_comb begin
    d0_d        = '0;
    d0_d.res    = res3_q;
    d0_d.neg    = neg3_q;
    d0_d.den    = den3_q;
    d0_d.ovf    = {hi_im >= den3_q, hi_re >= den3_q};
    d0_d.rem_re = hi_re;
    d0_d.rem_im = hi_im;
    d0_d.lo_re  = shl_re[31:0];
    d0_d.lo_im  = shl_im[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else begin
      dv_q[0] <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q[0] <= d0_d;
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    logic [64:0] t_re, t_im, df_re, df_im;
    logic        ge_re, ge_im;
    dstage_t     st_d;

    assign t_re  = {d_q[k-1].rem_re, d_q[k-1].lo_re[31]};
    assign t_im  = {d_q[k-1].rem_im, d_q[k-1].lo_im[31]};
    assign df_re = t_re - {1'b0, d_q[k-1].den};
    assign df_im = t_im - {1'b0, d_q[k-1].den};
    assign ge_re = ~df_re[64];
    assign ge_im = ~df_im[64];

    always_comb begin
      st_d        = d_q[k-1];
      st_d.rem_re = ge_re ? df_re[63:0] : t_re[63:0];
      st_d.rem_im = ge_im ? df_im[63:0] : t_im[63:0];
      st_d.lo_re  = {d_q[k-1].lo_re[30:0], 1'b0};
      st_d.lo_im  = {d_q[k-1].lo_im[30:0], 1'b0};
      st_d.q_re   = {d_q[k-1].q_re[30:0], ge_re};
      st_d.q_im   = {d_q[k-1].q_im[30:0], ge_im};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else begin
        dv_q[k] <= dv_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      d_q[k] <= st_d;
    end
  end

  // final sign, saturation and output register
  dstage_t                  dl;
  logic [32:0]              qs_re, qs_im;
  logic                     done_q, sat_q, dz_q;
  logic [31:0]              y_re_q, y_im_q;
  logic [31:0]              y_re_d, y_im_d;
  logic                     sat_d, dz_d;

  assign dl = d_q[DIV_STEPS];

  always_comb begin
    if (dl.neg[0]) begin
      qs_re = (dl.ovf[0] || dl.q_re > SAT_MIN) ? {1'b1, SAT_MIN} : {1'b0, 32'(-dl.q_re)};
    end else begin
      qs_re = (dl.ovf[0] || dl.q_re[31]) ? {1'b1, SAT_MAX} : {1'b0, dl.q_re};
    end
    if (dl.neg[1]) begin
      qs_im = (dl.ovf[1] || dl.q_im > SAT_MIN) ? {1'b1, SAT_MIN} : {1'b0, 32'(-dl.q_im)};
    end else begin
      qs_im = (dl.ovf[1] || dl.q_im[31]) ? {1'b1, SAT_MAX} : {1'b0, dl.q_im};
    end
    if (!dl.res.is_div) begin
      y_re_d = dl.res.y_re;
      y_im_d = dl.res.y_im;
      sat_d  = dl.res.sat;
      dz_d   = 1'b0;
    end else if (dl.res.dz) begin
      y_re_d = '0;
      y_im_d = '0;
      sat_d  = 1'b0;
      dz_d   = 1'b1;
    end else begin
      y_re_d = qs_re[31:0];
      y_im_d = qs_im[31:0];
      sat_d  = qs_re[32] | qs_im[32];
      dz_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      sat_q  <= 1'b0;
      dz_q   <= 1'b0;
    end else begin
      done_q <= dv_q[DIV_STEPS];
      sat_q  <= dv_q[DIV_STEPS] & sat_d;
      dz_q   <= dv_q[DIV_STEPS] & dz_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_re_q <= y_re_d;
    y_im_q <= y_im_d;
  end

  assign done_o        = done_q;
  assign y_re_o        = y_re_q;
  assign y_im_o        = y_im_q;
  assign saturated_o   = sat_q;
  assign div_by_zero_o = dz_q;

  // fixed latency in both directions
  a_lat_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("done strobe without matching start beat");

  a_lat_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LATENCY done_o)
    else $error("start beat lost in pipeline");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(saturated_o && div_by_zero_o))
    else $error("saturation and divide by zero flagged together");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_by_zero_o |-> (y_re_o == 32'd0 && y_im_o == 32'd0))
    else $error("divide by zero result not cleared");

  a_flags_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> (!saturated_o && !div_by_zero_o))
    else $error("flag raised without done strobe");

endmodule
`default_nettype wire

>>> tb/sv/complex_arith_unit_core_tb.sv
// self-checking testbench for the complex arithmetic unit core
`timescale 1ns / 1ps
`default_nettype none
module complex_arith_unit_core_tb;
  import cau_pkg::*;

  localparam int FRAC = 16;
  localparam int WATCHDOG = 2000;

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] a_re;
    logic [31:0] a_im;
    logic [31:0] b_re;
    logic [31:0] b_im;
  } op_t;

  typedef struct {
    logic [31:0] y_re;
    logic [31:0] y_im;
    logic        sat;
    logic        dz;
  } ans_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [2:0] cmd_i = '0;
  logic signed [31:0] a_re_i = '0, a_im_i = '0, b_re_i = '0, b_im_i = '0;
  logic busy_o, done_o, saturated_o, div_by_zero_o;
  logic signed [31:0] y_re_o, y_im_o;

  complex_arith_unit_core u_top (
    .clk_i, .rst_ni, .start_i, .busy_o, .cmd_i, .a_re_i, .a_im_i, .b_re_i, .b_im_i,
    .done_o, .y_re_o, .y_im_o, .saturated_o, .div_by_zero_o
  );

  op_t  pending_ops[$];
  ans_t expected_answers[$];
  int   errors = 0;
  int   idle_pct = 0;
  int   quiet_cycles = 0;
  bit   timed_out = 0;

  initial forever #5 clk_i = ~clk_i;

  function automatic logic [31:0] clip32(input logic signed [127:0] v, inout logic sat);
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return SAT_MAX;
    end
    if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return SAT_MIN;
    end
    return v[31:0];
  endfunction

  // round to nearest, ties up, from 2*FRAC fraction bits
  function automatic logic [31:0] round_clip(input logic signed [127:0] p, inout logic sat);
    logic signed [127:0] q;
    q = (p + (128'sd1 <<< (FRAC - 1))) >>> FRAC;
    return clip32(q, sat);
  endfunction

  // quotient truncated toward zero
  function automatic logic [31:0] quot_clip(input logic signed [127:0] n,
                                            input logic signed [127:0] d,
                                            inout logic sat);
    logic [127:0] mn, md, mq;
    logic neg;
    neg = (n < 0) != (d < 0);
    mn = (n < 0) ? -n : n;
    md = (d < 0) ? -d : d;
    mq = (mn << FRAC) / md;
    return clip32(neg ? -$signed(mq) : $signed(mq), sat);
  endfunction

  function automatic ans_t complex_result(input op_t op);
    ans_t r;
    logic signed [127:0] ar, ai, br, bi, den;
    ar = $signed(op.a_re);
    ai = $signed(op.a_im);
    br = $signed(op.b_re);
    bi = $signed(op.b_im);
    r = '{default: '0};
    case (op.cmd)
      CMD_ADD: begin
        r.y_re = clip32(ar + br, r.sat);
        r.y_im = clip32(ai + bi, r.sat);
      end
      CMD_SUB: begin
        r.y_re = clip32(ar - br, r.sat);
        r.y_im = clip32(ai - bi, r.sat);
      end
      CMD_MUL: begin
        r.y_re = round_clip(ar * br - ai * bi, r.sat);
        r.y_im = round_clip(ar * bi + br * ai, r.sat);
      end
      CMD_MULR: begin
        r.y_re = round_clip(ar * br, r.sat);
        r.y_im = round_clip(ai * br, r.sat);
      end
      CMD_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) r.dz = 1'b1;
        else begin
          r.y_re = quot_clip(ar * br + ai * bi, den, r.sat);
          r.y_im = quot_clip(ai * br - ar * bi, den, r.sat);
        end
      end
      CMD_DIVR: begin
        if (br == 0) r.dz = 1'b1;
        else begin
          r.y_re = quot_clip(ar, br, r.sat);
          r.y_im = quot_clip(ai, br, r.sat);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3, 4: return $urandom_range(0, 32'h3_ffff) - 32'h2_0000;
      5: return $urandom_range(0, 8) << 16;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_op(input logic [2:0] c, input logic [31:0] a_re, a_im, b_re, b_im);
    op_t op;
    op = '{c, a_re, a_im, b_re, b_im};
    pending_ops.push_back(op);
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && start_i && !busy_o) begin
      expected_answers.push_back(complex_result('{cmd_i, a_re_i, a_im_i, b_re_i, b_im_i}));
    end
    if (rst_ni && !(start_i && busy_o)) begin
      if (pending_ops.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        op_t op;
        op = pending_ops.pop_front();
        start_i <= 1'b1;
        cmd_i <= op.cmd;
        a_re_i <= op.a_re;
        a_im_i <= op.a_im;
        b_re_i <= op.b_re;
        b_im_i <= op.b_im;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (done_o) begin
        if (expected_answers.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          ans_t e;
          e = expected_answers.pop_front();
          if (y_re_o !== e.y_re) begin
            $error("y_re expected %h actual %h", e.y_re, y_re_o);
            errors++;
          end
          if (y_im_o !== e.y_im) begin
            $error("y_im expected %h actual %h", e.y_im, y_im_o);
            errors++;
          end
          if (saturated_o !== e.sat) begin
            $error("saturated expected %b actual %b", e.sat, saturated_o);
            errors++;
          end
          if (div_by_zero_o !== e.dz) begin
            $error("div_by_zero expected %b actual %b", e.dz, div_by_zero_o);
            errors++;
          end
        end
      end
      if (quiet_cycles >= WATCHDOG) timed_out = 1;
    end
  end

  task automatic drain();
    while ((pending_ops.size() != 0 || start_i || expected_answers.size() != 0) && !timed_out)
      @(posedge clk_i);
  endtask

  initial begin
    logic [2:0] c;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // extremes, every command, zero divisors, unused codes
    for (int k = 0; k < 8; k++) push_op(3'(k), 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                                        32'h8000_0000);
    for (int k = 0; k < 6; k++) push_op(3'(k), 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                        32'h8000_0000);
    push_op(CMD_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0);
    push_op(CMD_DIVR, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'hffff_ffff);
    push_op(CMD_DIVR, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 32'h0);
    push_op(CMD_MUL, 32'h0000_8000, 32'h0, 32'h0000_0001, 32'h0);
    push_op(CMD_MUL, 32'hffff_8000, 32'h0, 32'h0000_0001, 32'h0);
    push_op(CMD_DIV, 32'h0001_0000, 32'h0, 32'h0000_0001, 32'h0);
    push_op(CMD_ADD, 32'hffff_ffff, 32'h0, 32'h0, 32'hffff_ffff);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 12 : (phase == 1) ? 57 : 0;
      for (int n = 0; n < 300; n++) begin
        c = 3'(($urandom_range(0, 19) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5));
        push_op(c, rand_field(), rand_field(), rand_field(), rand_field());
      end
      drain();
    end

    repeat (LATENCY + 10) @(posedge clk_i);
    if (timed_out) begin
      $display("CHECK FAILED");
    end else if (errors == 0 && expected_answers.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
